/* design/assert_macros.svh */
// Assertion macros shared by the frame extractor modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds in the same cycle as the trigger.
`define ASSERT_IMPL(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// Condition holds in the cycle after the trigger.
`define ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

/* design/qcfe_pkg.sv */
// Types and constants of the QUIC crypto frame extractor.
package qcfe_pkg;

    localparam int CRYPTO_CAPACITY = 4096;
    localparam int TOTAL_W         = $clog2(CRYPTO_CAPACITY + 1);
    localparam int VARINT_W        = 62;

    // Frame type bytes
    localparam logic [7:0] FT_PADDING = 8'h00;
    localparam logic [7:0] FT_ACK     = 8'h02;
    localparam logic [7:0] FT_ACK_ECN = 8'h03;
    localparam logic [7:0] FT_CRYPTO  = 8'h06;
    localparam logic [7:0] FT_CC_QUIC = 8'h1c;
    localparam logic [7:0] FT_CC_APP  = 8'h1d;

    // Status / error codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_MALFORMED = 2'd1;
    localparam logic [1:0] ST_OVERFLOW  = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    typedef enum logic [3:0] {
        PH_TYPE,
        PH_VSTART,
        PH_VCONT,
        PH_SKIP,
        PH_DATA,
        PH_ERR
    } phase_t;

    typedef enum logic [2:0] {
        K_NONE,
        K_CRYPTO,
        K_ACK,
        K_ACKECN,
        K_CC1,
        K_CC2
    } kind_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       last_byte;
    } in_word_t;

    typedef struct packed {
        logic       data_valid;
        logic [7:0] data_byte;
        logic       done_res;
        logic [1:0] status;
    } out_word_t;

endpackage

/* design/qcfe_parser.sv */
// Frame walker: varint decoding, frame state and per-byte result.
`include "assert_macros.svh"

module qcfe_parser
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  qcfe_pkg::in_word_t  word,
    output logic                res_valid,
    output qcfe_pkg::out_word_t res
);

    qcfe_pkg::phase_t                 phase_reg, phase_next;
    qcfe_pkg::kind_t                  kind_reg, kind_next;
    logic [2:0]                       field_reg, field_next;
    logic [qcfe_pkg::VARINT_W-1:0]    accum_reg, accum_next;
    logic [2:0]                       left_reg, left_next;
    logic [qcfe_pkg::VARINT_W-1:0]    skip_reg, skip_next;
    logic [qcfe_pkg::VARINT_W-1:0]    ranges_reg, ranges_next;
    logic [qcfe_pkg::TOTAL_W-1:0]     total_reg, total_next;
    logic [1:0]                       err_reg, err_next;

    logic                             field_done;
    logic                             data;
    logic [7:0]                       b;
    logic [qcfe_pkg::TOTAL_W-1:0]     room;
    logic [1:0]                       status;

    localparam logic [qcfe_pkg::TOTAL_W-1:0] CAP_T =
        qcfe_pkg::TOTAL_W'(qcfe_pkg::CRYPTO_CAPACITY);

    assign b    = word.payload_byte;
    assign room = CAP_T - total_reg;

    always_comb
    begin
        phase_next  = phase_reg;
        kind_next   = kind_reg;
        field_next  = field_reg;
        accum_next  = accum_reg;
        left_next   = left_reg;
        skip_next   = skip_reg;
        ranges_next = ranges_reg;
        total_next  = total_reg;
        err_next    = err_reg;
        field_done  = 1'b0;
        data        = 1'b0;
        status      = qcfe_pkg::ST_OK;

        case (phase_reg)
            qcfe_pkg::PH_TYPE:
            begin
                kind_next  = qcfe_pkg::K_NONE;
                field_next = 3'd0;
                phase_next = qcfe_pkg::PH_VSTART;
                case (b)
                    qcfe_pkg::FT_PADDING:
                    begin
                        field_next = field_reg;
                        phase_next = qcfe_pkg::PH_TYPE;
                    end
                    qcfe_pkg::FT_ACK:     kind_next = qcfe_pkg::K_ACK;
                    qcfe_pkg::FT_ACK_ECN: kind_next = qcfe_pkg::K_ACKECN;
                    qcfe_pkg::FT_CRYPTO:  kind_next = qcfe_pkg::K_CRYPTO;
                    qcfe_pkg::FT_CC_QUIC: kind_next = qcfe_pkg::K_CC1;
                    qcfe_pkg::FT_CC_APP:  kind_next = qcfe_pkg::K_CC2;
                    default:
                    begin
                        field_next = field_reg;
                        err_next   = (err_reg == qcfe_pkg::ST_OK) ?
                                     qcfe_pkg::ST_MALFORMED : err_reg;
                        phase_next = qcfe_pkg::PH_ERR;
                    end
                endcase
            end
            qcfe_pkg::PH_VSTART:
            begin
                // length prefix 1, 2, 4 or 8 bytes: remaining count 0, 1, 3, 7
                accum_next = {{(qcfe_pkg::VARINT_W-6){1'b0}}, b[5:0]};
                left_next  = {b[7] & b[6], b[7], b[7] | b[6]};
                if (b[7:6] == 2'b00)
                    field_done = 1'b1;
                else
                    phase_next = qcfe_pkg::PH_VCONT;
            end
            qcfe_pkg::PH_VCONT:
            begin
                accum_next = {accum_reg[qcfe_pkg::VARINT_W-9:0], b};
                left_next  = left_reg - 3'd1;
                if (left_next == 3'd0)
                    field_done = 1'b1;
            end
            qcfe_pkg::PH_SKIP,
            qcfe_pkg::PH_DATA:
            begin
                data      = (phase_reg == qcfe_pkg::PH_DATA);
                skip_next = skip_reg - qcfe_pkg::VARINT_W'(1);
                if (skip_next == '0)
                    phase_next = qcfe_pkg::PH_TYPE;
            end
            default:
            begin
                // error: drop bytes until the last one
            end
        endcase

        if (field_done)
        begin
            case (kind_reg)
                qcfe_pkg::K_CRYPTO:
                begin
                    if (field_reg == 3'd0)
                    begin
                        field_next = 3'd1;
                        phase_next = qcfe_pkg::PH_VSTART;
                    end
                    else if (accum_next > qcfe_pkg::VARINT_W'(room))
                    begin
                        err_next   = (err_reg == qcfe_pkg::ST_OK) ?
                                     qcfe_pkg::ST_OVERFLOW : err_reg;
                        phase_next = qcfe_pkg::PH_ERR;
                    end
                    else
                    begin
                        total_next = total_reg + accum_next[qcfe_pkg::TOTAL_W-1:0];
                        if (accum_next == '0)
                            phase_next = qcfe_pkg::PH_TYPE;
                        else
                        begin
                            skip_next  = accum_next;
                            phase_next = qcfe_pkg::PH_DATA;
                        end
                    end
                end
                qcfe_pkg::K_ACK,
                qcfe_pkg::K_ACKECN:
                begin
                    phase_next = qcfe_pkg::PH_VSTART;
                    case (field_reg)
                        3'd0: field_next = 3'd1;
                        3'd1: field_next = 3'd2;
                        3'd2:
                        begin
                            ranges_next = accum_next;
                            field_next  = 3'd3;
                        end
                        3'd3,
                        3'd5:
                        begin
                            if (field_reg == 3'd5)
                                ranges_next = ranges_reg - qcfe_pkg::VARINT_W'(1);
                            if (ranges_next != '0)
                                field_next = 3'd4;
                            else if (kind_reg == qcfe_pkg::K_ACKECN)
                            begin
                                // three ECN counts follow the ranges
                                ranges_next = qcfe_pkg::VARINT_W'(3);
                                field_next  = 3'd6;
                            end
                            else
                                phase_next = qcfe_pkg::PH_TYPE;
                        end
                        3'd4: field_next = 3'd5;
                        default:
                        begin
                            ranges_next = ranges_reg - qcfe_pkg::VARINT_W'(1);
                            if (ranges_next != '0)
                                field_next = 3'd6;
                            else
                                phase_next = qcfe_pkg::PH_TYPE;
                        end
                    endcase
                end
                qcfe_pkg::K_CC1,
                qcfe_pkg::K_CC2:
                begin
                    if ((kind_reg == qcfe_pkg::K_CC1 && field_reg < 3'd2) ||
                        (kind_reg == qcfe_pkg::K_CC2 && field_reg == 3'd0))
                    begin
                        field_next = field_reg + 3'd1;
                        phase_next = qcfe_pkg::PH_VSTART;
                    end
                    else if (accum_next == '0)
                        phase_next = qcfe_pkg::PH_TYPE;
                    else
                    begin
                        skip_next  = accum_next;
                        phase_next = qcfe_pkg::PH_SKIP;
                    end
                end
                default:
                begin
                    err_next   = (err_reg == qcfe_pkg::ST_OK) ?
                                 qcfe_pkg::ST_MALFORMED : err_reg;
                    phase_next = qcfe_pkg::PH_ERR;
                end
            endcase
        end

        if (word.last_byte)
        begin
            if (err_next != qcfe_pkg::ST_OK)
                status = err_next;
            else if (phase_next != qcfe_pkg::PH_TYPE)
                status = qcfe_pkg::ST_MALFORMED;
            else if (total_next == '0)
                status = qcfe_pkg::ST_EMPTY;
            else
                status = qcfe_pkg::ST_OK;

            phase_next  = qcfe_pkg::PH_TYPE;
            kind_next   = qcfe_pkg::K_NONE;
            field_next  = 3'd0;
            accum_next  = '0;
            left_next   = 3'd0;
            skip_next   = '0;
            ranges_next = '0;
            total_next  = '0;
            err_next    = qcfe_pkg::ST_OK;
        end
    end

    assign res_valid      = step && (data || word.last_byte);
    assign res.data_valid = data;
    assign res.data_byte  = data ? b : 8'd0;
    assign res.done_res   = word.last_byte;
    assign res.status     = status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= qcfe_pkg::PH_TYPE;
            kind_reg   <= qcfe_pkg::K_NONE;
            field_reg  <= 3'd0;
            accum_reg  <= '0;
            left_reg   <= 3'd0;
            skip_reg   <= '0;
            ranges_reg <= '0;
            total_reg  <= '0;
            err_reg    <= qcfe_pkg::ST_OK;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            kind_reg   <= kind_next;
            field_reg  <= field_next;
            accum_reg  <= accum_next;
            left_reg   <= left_next;
            skip_reg   <= skip_next;
            ranges_reg <= ranges_next;
            total_reg  <= total_next;
            err_reg    <= err_next;
        end
    end

    `ASSERT_IMPL(a_err_parks, err_reg != qcfe_pkg::ST_OK, phase_reg == qcfe_pkg::PH_ERR, "error without error phase")
    `ASSERT_IMPL(a_total_cap, 1'b1, total_reg <= CAP_T, "crypto total above capacity")
    `ASSERT_NEXT(a_last_clears, step && word.last_byte, phase_reg == qcfe_pkg::PH_TYPE && total_reg == '0, "state not cleared after last byte")

endmodule

/* design/quic_crypto_frame_extractor.sv */
// Result words are registered: the result register, or the skid entry first while output stalls.
// One payload word per cycle while the skid is free; frame state updates in one pass per byte.
// A two-entry output buffer (result register plus skid) keeps input flowing while output stalls;
// payload_ready drops only while the skid entry is occupied.
// Reset (rst_n low, asynchronous): parser returns to expect-frame-type, buffers empty.
`include "assert_macros.svh"

module quic_crypto_frame_extractor
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                payload_valid,
    output logic                payload_ready,
    input  qcfe_pkg::in_word_t  payload,
    output logic                result_valid,
    input  logic                result_ready,
    output qcfe_pkg::out_word_t result
);

    logic                step;
    logic                push;
    qcfe_pkg::out_word_t push_word;

    logic                out_valid_reg;
    qcfe_pkg::out_word_t out_word_reg;
    logic                skid_valid_reg;
    qcfe_pkg::out_word_t skid_word_reg;

    // Accept a word whenever the skid entry is free: at most one result per byte,
    // so a free skid always has room for it.
    assign payload_ready = !skid_valid_reg;
    assign step          = payload_valid && payload_ready;

    qcfe_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .word      (payload),
        .res_valid (push),
        .res       (push_word)
    );

    // Output buffer: the result register feeds the port; the skid entry
    // catches a result produced while the port is stalled.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (result_ready || !out_valid_reg)
        begin
            // advance: drain the skid first, otherwise load the fresh result
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= push;
        end
        else if (push)
            skid_valid_reg <= 1'b1;   // hold the new result behind the stalled one
    end

    always_ff @(posedge clk)
    begin
        if (result_ready || !out_valid_reg)
            out_word_reg <= skid_valid_reg ? skid_word_reg : push_word;
        else if (push)
            skid_word_reg <= push_word;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_word_reg;

    `ASSERT_IMPL(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid entry full while result register empty")

endmodule
